/* hdl/ddo_pkg.sv */
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and tables for the differential drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  // Fixed point constants, Q16.16
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int PI_Q             = 205887;
  localparam int HALF_PI_Q        = 102944;
  localparam int TWO_PI_Q         = 411775;
  localparam int CORDIC_GAIN      = 39797;

  // Shared unit widths
  localparam int CW   = 36;   // CORDIC datapath
  localparam int MAW  = 36;   // multiplier operand a
  localparam int MBW  = 18;   // multiplier operand b
  localparam int MPW  = MAW + MBW;

  // Bias that keeps the heading positive during the modulo sweep
  localparam int          RED_W    = 34;
  localparam int          RED_TOP  = 14;
  localparam logic [33:0] RED_BIAS = 34'(longint'(TWO_PI_Q) * 64'd8192);

  // Reset values of registers
  localparam logic [23:0] DPT_RST        = 24'd65536;
  localparam logic [23:0] HALF_TRACK_RST = 24'd8388608;

  // Register indexes
  localparam int          CFG_AW             = 3;
  localparam logic [2:0]  REG_DIST_PER_TICK  = 3'd0;
  localparam logic [2:0]  REG_HEADING_OFFSET = 3'd1;
  localparam logic [2:0]  REG_BASE_X         = 3'd2;
  localparam logic [2:0]  REG_BASE_Y         = 3'd3;
  localparam logic [2:0]  REG_HALF_TRACK     = 3'd4;

  typedef struct packed {
    logic signed [15:0] left_ticks;
    logic signed [15:0] right_ticks;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] heading;
    logic        [31:0] base_distance;
  } out_item_t;

  // Request to the CORDIC unit
  typedef struct packed {
    logic                 start;
    logic                 vec_mode;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] z0;
  } cordic_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_ROT_START,
    ST_ROT_WAIT,
    ST_WHEEL,
    ST_VEC_START,
    ST_VEC_WAIT,
    ST_TURN_MUL,
    ST_TURN_POS,
    ST_TURN_SEL,
    ST_ORI_MUL,
    ST_ORI,
    ST_SQ,
    ST_SQRT_START,
    ST_SQRT_WAIT,
    ST_DONE
  } state_t;

  // atan(2^-i) in Q16.16
  function automatic logic [15:0] atan_q(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30385;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/ddo_mul.sv */
// ----------------------------------------------------------------------------
// ddo_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ddo_mul (
  input  logic                               clk,
  input  logic signed [ddo_pkg::MAW-1:0]     a,
  input  logic signed [ddo_pkg::MBW-1:0]     b,
  output logic signed [ddo_pkg::MPW-1:0]     prod
);

  // one product per cycle, valid the cycle after the operands
  always_ff @(posedge clk) begin
    prod <= ddo_pkg::MPW'(a) * ddo_pkg::MPW'(b);
  end

endmodule

/* hdl/ddo_cordic.sv */
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module ddo_cordic #(
  parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ddo_pkg::cordic_req_t           req,
  output logic signed [ddo_pkg::CW-1:0]  x,
  output logic signed [ddo_pkg::CW-1:0]  y,
  output logic signed [ddo_pkg::CW-1:0]  z,
  output logic                           done
);

  localparam int IW = $clog2(STEPS);

  logic          busy;
  logic          vec;
  logic [IW-1:0] it;
  logic signed [ddo_pkg::CW-1:0] xs, ys, at;
  logic          dir_pos;

  // shifted terms and direction of this step
  always_comb begin
    xs      = x >>> it;
    ys      = y >>> it;
    at      = ddo_pkg::CW'(ddo_pkg::atan_q(5'(it)));
    dir_pos = vec ? (y >= 0) : (z >= 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      it   <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        vec  <= req.vec_mode;
        it   <= '0;
        x    <= req.x0;
        y    <= req.y0;
        z    <= req.z0;
      end else if (busy) begin
        if (vec) begin
          if (dir_pos) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end
        end else begin
          if (dir_pos) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
        end
        if (it == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          it <= it + 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/ddo_isqrt.sv */
// ----------------------------------------------------------------------------
// ddo_isqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module ddo_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic [31:0] root,
  output logic        done
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitr;
  logic [63:0] trial;

  assign trial = res + bitr;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= value;
        res  <= '0;
        bitr <= 64'd1 << 62;
      end else if (busy) begin
        // restoring step
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitr;
        end else begin
          res <= res >> 1;
        end
        bitr <= bitr >> 2;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/differential_drive_odometry.sv */
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Wheel-point odometry: sin/cos of the held heading, wheel moves, heading by
// vectoring CORDIC, turn unwrapping and distance to a base point.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                  | payload
//  item      | in        | item_valid / item_ready    | ddo_pkg::in_item_t
//  result    | out       | result_valid / result_ready| ddo_pkg::out_item_t
//  config    | in        | cfg_we                     | cfg_index, cfg_data
//
//  Each item runs a modulo sweep of the heading, a rotating CORDIC pass, the
//  wheel products, a vectoring pass (skipped when the wheel points coincide)
//  and a 32-step square root, all on one multiplier and one CORDIC unit.
//  item_ready is high only in idle; the result register holds a transfer
//  until taken, and the next item waits at the end if it is not yet taken.
//  Reset is synchronous and returns state, registers and wheel positions to their reset values.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  ddo_pkg::in_item_t            item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output ddo_pkg::out_item_t           result,
  input  logic                         cfg_we,
  input  logic [ddo_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [31:0]                  cfg_data
);

  localparam int CW  = ddo_pkg::CW;
  localparam int MPW = ddo_pkg::MPW;

  ddo_pkg::state_t state, state_next;

  // configuration
  logic        [23:0] dist_per_tick;
  logic signed [31:0] heading_offset;
  logic signed [31:0] base_x;
  logic signed [31:0] base_y;

  // odometry state
  logic signed [31:0] left_wheel_x, left_wheel_y, right_wheel_x, right_wheel_y;
  logic signed [15:0] turn_count;
  logic signed [31:0] held_heading;

  // working registers
  logic [4:0]               seq;
  logic signed [15:0]       lt, rt;
  logic [ddo_pkg::RED_W-1:0] red;
  logic                     flip;
  logic signed [17:0]       sin_v, cos_v;
  logic signed [35:0]       p_reg;
  logic signed [59:0]       acc;
  logic                     dyw_neg;
  logic signed [19:0]       angle;
  logic signed [35:0]       raw;
  logic signed [39:0]       pos;
  logic signed [17:0]       ori_mult;
  logic signed [31:0]       cx, cy;
  logic [31:0]              ex, ey;
  logic [65:0]              sq;

  // shared units
  logic signed [ddo_pkg::MAW-1:0] mul_a;
  logic signed [ddo_pkg::MBW-1:0] mul_b;
  logic signed [MPW-1:0]          prod;
  ddo_pkg::cordic_req_t           creq;
  logic signed [CW-1:0]           cx_o, cy_o, cz_o;
  logic                           cdone;
  logic                           sqrt_start;
  logic [31:0]                    sqrt_root;
  logic                           sqrt_done;

  // combinational helpers
  logic [18:0]        r_mod;
  logic signed [19:0] r2, r3;
  logic               flip_c;
  logic signed [31:0] dxw, dyw;
  logic signed [32:0] ady;
  logic               vec_zero;
  logic signed [59:0] wtotal;
  logic signed [31:0] wdelta;
  logic signed [35:0] meas;
  logic signed [39:0] neg;
  logic signed [39:0] apos, aneg;
  logic signed [32:0] sumx, sumy, difx, dify;
  logic [65:0]        sq_add;

  ddo_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .req  (creq),
    .x    (cx_o),
    .y    (cy_o),
    .z    (cz_o),
    .done (cdone)
  );

  ddo_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (sq[63:0]),
    .root  (sqrt_root),
    .done  (sqrt_done)
  );

  // angle folding, wheel vector, wheel delta, turn compare, center, square sum
  always_comb begin
    r_mod  = red[18:0];
    r2     = (r_mod > 19'(ddo_pkg::PI_Q)) ? 20'(r_mod) - 20'(ddo_pkg::TWO_PI_Q)
                                         : 20'(r_mod);
    flip_c = 1'b0;
    r3     = r2;
    if (r2 > 20'(ddo_pkg::HALF_PI_Q)) begin
      r3     = r2 - 20'(ddo_pkg::PI_Q);
      flip_c = 1'b1;
    end else if (r2 < -20'(ddo_pkg::HALF_PI_Q)) begin
      r3     = r2 + 20'(ddo_pkg::PI_Q);
      flip_c = 1'b1;
    end

    dxw      = right_wheel_x - left_wheel_x;
    dyw      = right_wheel_y - left_wheel_y;
    ady      = (dyw < 0) ? -33'(dyw) : 33'(dyw);
    vec_zero = (dxw == 0) && (dyw == 0);

    wtotal = acc + (60'(prod) <<< 12);
    wdelta = 32'(wtotal >>> 16);

    meas = 36'(angle) + 36'(heading_offset);
    neg  = pos - 40'(ddo_pkg::TWO_PI_Q);
    apos = (pos < 0) ? -pos : pos;
    aneg = (neg < 0) ? -neg : neg;

    sumx = 33'(left_wheel_x) + 33'(right_wheel_x);
    sumy = 33'(left_wheel_y) + 33'(right_wheel_y);
    difx = 33'(cx) - 33'(base_x);
    dify = 33'(cy) - 33'(base_y);

    sq_add = seq[0] ? 66'(prod[47:0]) : (66'(prod[47:0]) << 16);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ddo_pkg::ST_IDLE:       if (item_valid) state_next = ddo_pkg::ST_REDUCE;
      ddo_pkg::ST_REDUCE:     if (seq == 5'd0) state_next = ddo_pkg::ST_ROT_START;
      ddo_pkg::ST_ROT_START:  state_next = ddo_pkg::ST_ROT_WAIT;
      ddo_pkg::ST_ROT_WAIT:   if (cdone) state_next = ddo_pkg::ST_WHEEL;
      ddo_pkg::ST_WHEEL:      if (seq == 5'd15) state_next = ddo_pkg::ST_VEC_START;
      ddo_pkg::ST_VEC_START:  state_next = vec_zero ? ddo_pkg::ST_TURN_MUL
                                                    : ddo_pkg::ST_VEC_WAIT;
      ddo_pkg::ST_VEC_WAIT:   if (cdone) state_next = ddo_pkg::ST_TURN_MUL;
      ddo_pkg::ST_TURN_MUL:   state_next = ddo_pkg::ST_TURN_POS;
      ddo_pkg::ST_TURN_POS:   state_next = ddo_pkg::ST_TURN_SEL;
      ddo_pkg::ST_TURN_SEL:   state_next = ddo_pkg::ST_ORI_MUL;
      ddo_pkg::ST_ORI_MUL:    state_next = ddo_pkg::ST_ORI;
      ddo_pkg::ST_ORI:        state_next = ddo_pkg::ST_SQ;
      ddo_pkg::ST_SQ:         if (seq == 5'd4) state_next = ddo_pkg::ST_SQRT_START;
      ddo_pkg::ST_SQRT_START: state_next = sq[64] ? ddo_pkg::ST_DONE
                                                  : ddo_pkg::ST_SQRT_WAIT;
      ddo_pkg::ST_SQRT_WAIT:  if (sqrt_done) state_next = ddo_pkg::ST_DONE;
      ddo_pkg::ST_DONE:       if (!result_valid || result_ready)
                                state_next = ddo_pkg::ST_IDLE;
      default:                state_next = ddo_pkg::ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    item_ready    = (state == ddo_pkg::ST_IDLE);
    mul_a         = '0;
    mul_b         = '0;
    creq          = '0;
    sqrt_start    = 1'b0;
    case (state)
      ddo_pkg::ST_ROT_START: begin
        creq.start    = 1'b1;
        creq.vec_mode = 1'b0;
        creq.x0       = CW'(ddo_pkg::CORDIC_GAIN);
        creq.y0       = '0;
        creq.z0       = CW'(r3);
      end
      ddo_pkg::ST_WHEEL: begin
        case (seq[1:0])
          2'd0: begin
            mul_a = 36'(seq[3] ? rt : lt);
            mul_b = seq[2] ? cos_v : sin_v;
          end
          2'd1: begin
            mul_a = prod[35:0];
            mul_b = 18'({6'd0, dist_per_tick[11:0]});
          end
          2'd2: begin
            mul_a = p_reg;
            mul_b = 18'({6'd0, dist_per_tick[23:12]});
          end
          default: ;
        endcase
      end
      ddo_pkg::ST_VEC_START: begin
        creq.start    = !vec_zero;
        creq.vec_mode = 1'b1;
        if (dxw < 0) begin
          creq.x0 = CW'(ady);
          creq.y0 = -CW'(dxw);
          creq.z0 = CW'(ddo_pkg::HALF_PI_Q);
        end else begin
          creq.x0 = CW'(dxw);
          creq.y0 = CW'(ady);
          creq.z0 = '0;
        end
      end
      ddo_pkg::ST_TURN_MUL: begin
        mul_a = 36'(ddo_pkg::TWO_PI_Q);
        mul_b = 18'(turn_count);
      end
      ddo_pkg::ST_ORI_MUL: begin
        mul_a = 36'(ddo_pkg::TWO_PI_Q);
        mul_b = ori_mult;
      end
      ddo_pkg::ST_SQ: begin
        case (seq[2:0])
          3'd0: begin mul_a = 36'({4'd0, ex}); mul_b = 18'({2'd0, ex[15:0]}); end
          3'd1: begin mul_a = 36'({4'd0, ex}); mul_b = 18'({2'd0, ex[31:16]}); end
          3'd2: begin mul_a = 36'({4'd0, ey}); mul_b = 18'({2'd0, ey[15:0]}); end
          3'd3: begin mul_a = 36'({4'd0, ey}); mul_b = 18'({2'd0, ey[31:16]}); end
          default: ;
        endcase
      end
      ddo_pkg::ST_SQRT_START: sqrt_start = !sq[64];
      default: ;
    endcase
  end

  // registers and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ddo_pkg::ST_IDLE;
      seq            <= '0;
      dist_per_tick  <= ddo_pkg::DPT_RST;
      heading_offset <= '0;
      base_x         <= '0;
      base_y         <= '0;
      left_wheel_x   <= -32'(ddo_pkg::HALF_TRACK_RST);
      right_wheel_x  <= 32'(ddo_pkg::HALF_TRACK_RST);
      left_wheel_y   <= '0;
      right_wheel_y  <= '0;
      turn_count     <= '0;
      held_heading   <= '0;
      result_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (result_valid && result_ready) result_valid <= 1'b0;

      // configuration writes; the user must write only while idle, the block itself does not enforce it
      if (cfg_we) begin
        case (cfg_index)
          ddo_pkg::REG_DIST_PER_TICK:  dist_per_tick  <= cfg_data[23:0];
          ddo_pkg::REG_HEADING_OFFSET: heading_offset <= cfg_data;
          ddo_pkg::REG_BASE_X:         base_x         <= cfg_data;
          ddo_pkg::REG_BASE_Y:         base_y         <= cfg_data;
          ddo_pkg::REG_HALF_TRACK: begin
            left_wheel_x  <= -32'(cfg_data[23:0]);
            right_wheel_x <= 32'(cfg_data[23:0]);
            left_wheel_y  <= '0;
            right_wheel_y <= '0;
          end
          default: ;
        endcase
      end

      case (state)
        ddo_pkg::ST_IDLE: begin
          if (item_valid) begin
            lt  <= item.left_ticks;
            rt  <= item.right_ticks;
            red <= ddo_pkg::RED_W'(held_heading) + ddo_pkg::RED_BIAS;
            seq <= 5'(ddo_pkg::RED_TOP);
          end
        end
        // heading modulo 2*pi, one trial subtract per cycle
        ddo_pkg::ST_REDUCE: begin
          if (red >= (ddo_pkg::RED_W'(ddo_pkg::TWO_PI_Q) << seq[3:0]))
            red <= red - (ddo_pkg::RED_W'(ddo_pkg::TWO_PI_Q) << seq[3:0]);
          seq <= seq - 1'b1;
        end
        ddo_pkg::ST_ROT_START: flip <= flip_c;
        ddo_pkg::ST_ROT_WAIT: begin
          if (cdone) begin
            sin_v <= flip ? -18'(cy_o) : 18'(cy_o);
            cos_v <= flip ? -18'(cx_o) : 18'(cx_o);
            seq   <= '0;
          end
        end
        // wheel moves: ticks*trig, then times distance per tick in halves
        ddo_pkg::ST_WHEEL: begin
          seq <= seq + 1'b1;
          case (seq[1:0])
            2'd1: p_reg <= prod[35:0];
            2'd2: acc   <= 60'(prod);
            2'd3: begin
              case (seq[3:2])
                2'd0:    left_wheel_x  <= left_wheel_x - wdelta;
                2'd1:    left_wheel_y  <= left_wheel_y + wdelta;
                2'd2:    right_wheel_x <= right_wheel_x - wdelta;
                default: right_wheel_y <= right_wheel_y + wdelta;
              endcase
            end
            default: ;
          endcase
        end
        ddo_pkg::ST_VEC_START: begin
          dyw_neg <= dyw[31];
          angle   <= '0;
        end
        ddo_pkg::ST_VEC_WAIT: begin
          if (cdone) begin
            if (cz_o < 0)
              angle <= '0;
            else if (cz_o > CW'(ddo_pkg::PI_Q))
              angle <= 20'(ddo_pkg::PI_Q);
            else
              angle <= 20'(cz_o);
          end
        end
        ddo_pkg::ST_TURN_MUL: begin
          raw <= dyw_neg ? 36'(ddo_pkg::TWO_PI_Q) - meas : meas;
        end
        ddo_pkg::ST_TURN_POS: begin
          pos <= 40'(raw) + 40'(prod) - 40'(held_heading);
        end
        // pick the nearer branch and step the turn count
        ddo_pkg::ST_TURN_SEL: begin
          if (apos < aneg) begin
            if (pos < -40'(ddo_pkg::PI_Q)) begin
              turn_count <= turn_count + 16'sd1;
              ori_mult   <= 18'(16'(turn_count + 16'sd1));
            end else begin
              ori_mult   <= 18'(turn_count);
            end
          end else begin
            if (neg > 40'(ddo_pkg::PI_Q)) begin
              turn_count <= turn_count - 16'sd1;
              ori_mult   <= 18'(16'(turn_count - 16'sd1)) - 18'sd1;
            end else begin
              ori_mult   <= 18'(turn_count) - 18'sd1;
            end
          end
        end
        ddo_pkg::ST_ORI_MUL: begin
          cx <= 32'(sumx >>> 1);
          cy <= 32'(sumy >>> 1);
        end
        ddo_pkg::ST_ORI: begin
          held_heading <= 32'(raw) + 32'(prod);
          ex  <= (difx < 0) ? 32'(-difx) : 32'(difx);
          ey  <= (dify < 0) ? 32'(-dify) : 32'(dify);
          seq <= '0;
          sq  <= '0;
        end
        // sum of squares, four partial products
        ddo_pkg::ST_SQ: begin
          seq <= seq + 1'b1;
          if (seq != 5'd0) sq <= sq + sq_add;
        end
        ddo_pkg::ST_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid         <= 1'b1;
            result.center_x      <= cx;
            result.center_y      <= cy;
            result.heading       <= held_heading;
            result.base_distance <= sq[64] ? 32'hFFFF_FFFF : sqrt_root;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
